// ===== sv/atis_pkg.sv =====
// atis_pkg: shared types, codes and helper functions for the integer token scanner
// no dependencies; used by atis_step, ascii_integer_token_scanner_core and tb_top
package atis_pkg;

   // configuration register indexes
   localparam logic CSR_CONVERSION  = 1'b0;
   localparam logic CSR_RESULT_SIZE = 1'b1;

   // conversion codes
   localparam logic [2:0] CONV_SIGNED_DEC   = 3'd0;
   localparam logic [2:0] CONV_SIGNED_AUTO  = 3'd1;
   localparam logic [2:0] CONV_UNSIGNED_OCT = 3'd2;
   localparam logic [2:0] CONV_UNSIGNED_HEX = 3'd4;

   // result size codes
   localparam logic [1:0] SIZE_8  = 2'd0;
   localparam logic [1:0] SIZE_16 = 2'd1;
   localparam logic [1:0] SIZE_32 = 2'd2;
   localparam logic [1:0] SIZE_64 = 2'd3;

   localparam logic [1:0] SIZE_RESET = SIZE_32;
   localparam logic [1:0] DIGIT_SAT  = 2'd2;

   // status codes
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_NO_DIGIT = 1'b1;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LO_X  = 8'h78;
   localparam logic [7:0] CH_UP_X  = 8'h58;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_F  = 8'h46;

   typedef enum logic [1:0] {
      BASE_AUTO,
      BASE_8,
      BASE_10,
      BASE_16
   } base_type;

   typedef struct packed {
      logic [1:0] digit_count;
      logic       negative_seen;
      logic       leading_zero_seen;
      logic       base_fixed;
      base_type   current_base;
   } ctrl_type;

   typedef struct packed {
      logic       status;
      logic [2:0] pushback_count;
   } result_type;

   function automatic base_type base_of_conversion(input logic [2:0] conv);
      base_type b;
      unique case (conv)
         CONV_SIGNED_AUTO:  b = BASE_AUTO;
         CONV_UNSIGNED_OCT: b = BASE_8;
         CONV_UNSIGNED_HEX: b = BASE_16;
         default:           b = BASE_10;
      endcase
      return b;
   endfunction

   function automatic logic conversion_signed(input logic [2:0] conv);
      return (conv == CONV_SIGNED_DEC) || (conv == CONV_SIGNED_AUTO);
   endfunction

   function automatic ctrl_type fresh_ctrl(input logic [2:0] conv);
      ctrl_type c;
      c.digit_count       = '0;
      c.negative_seen     = 1'b0;
      c.leading_zero_seen = 1'b0;
      c.base_fixed        = 1'b0;
      c.current_base      = base_of_conversion(conv);
      return c;
   endfunction

   // numeric radix; auto mode counts as zero so nothing but '0' is a digit
   function automatic logic [4:0] base_radix(input base_type b);
      logic [4:0] r;
      unique case (b)
         BASE_8:  r = 5'd8;
         BASE_10: r = 5'd10;
         BASE_16: r = 5'd16;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   // raw digit value of a character, 5'h1f when it is no hex digit at all
   function automatic logic [4:0] raw_digit(input logic [7:0] ch);
      logic [4:0] v;
      v = 5'h1f;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
         v = 5'(ch - CH_ZERO);
      end else if (ch >= CH_LO_A && ch <= CH_LO_F) begin
         v = 5'(ch - CH_LO_A + 8'd10);
      end else if (ch >= CH_UP_A && ch <= CH_UP_F) begin
         v = 5'(ch - CH_UP_A + 8'd10);
      end
      return v;
   endfunction

endpackage

// ===== sv/atis_step.sv =====
// atis_step: per-character next-state and result logic of the token scanner
// depends on atis_pkg; purely combinational, instantiated by the core
module atis_step #(
   parameter int UNDO_DEPTH = 4,
   parameter int VALUE_BITS = 64,
   parameter int REC_BITS   = 3
) (
   input  logic [7:0]            character,
   input  logic                  end_of_input,
   input  logic [2:0]            conversion,
   input  logic [1:0]            result_size,
   input  atis_pkg::ctrl_type    ctrl_cur,
   input  logic [VALUE_BITS-1:0] acc_cur,
   input  logic [REC_BITS-1:0]   rec_cur,
   output atis_pkg::ctrl_type    ctrl_next,
   output logic [VALUE_BITS-1:0] acc_next,
   output logic [REC_BITS-1:0]   rec_next,
   output logic                  has_result,
   output atis_pkg::result_type  result,
   output logic [63:0]           value
);

   logic                  is_space;
   logic                  is_zero;
   logic                  is_x;
   logic                  is_oct;
   logic                  is_dec;
   logic                  base_auto_8_16;
   logic                  take_minus;
   logic                  lz_now;
   logic                  take_x;
   logic                  take_oct;
   logic                  take_dec;
   logic [REC_BITS-1:0]   rec_inc;
   atis_pkg::base_type    base_now;
   logic [4:0]            raw_dv;
   logic                  dv_ok;
   logic [VALUE_BITS-1:0] scaled;
   logic [VALUE_BITS-1:0] signed_acc;
   logic [63:0]           wide_acc;
   logic [63:0]           size_mask;

   // character classes, none of them match at the end mark
   assign is_space = !end_of_input && ((character == atis_pkg::CH_SPACE) ||
                     (character >= atis_pkg::CH_TAB && character <= atis_pkg::CH_CR));
   assign is_zero  = !end_of_input && (character == atis_pkg::CH_ZERO);
   assign is_x     = !end_of_input && ((character == atis_pkg::CH_LO_X) ||
                                       (character == atis_pkg::CH_UP_X));
   assign is_oct   = !end_of_input && (character >= atis_pkg::CH_ZERO) &&
                     (character <= atis_pkg::CH_SEVEN);
   assign is_dec   = !end_of_input && (character >= atis_pkg::CH_ZERO) &&
                     (character <= atis_pkg::CH_NINE);

   assign base_auto_8_16 = (ctrl_cur.current_base != atis_pkg::BASE_10);

   assign take_minus = !end_of_input && (character == atis_pkg::CH_MINUS) &&
                       atis_pkg::conversion_signed(conversion) &&
                       !ctrl_cur.negative_seen && (ctrl_cur.digit_count == 2'd0) &&
                       !ctrl_cur.base_fixed;

   assign lz_now = ctrl_cur.leading_zero_seen ||
                   ((ctrl_cur.digit_count == 2'd0) && is_zero && !ctrl_cur.base_fixed &&
                    base_auto_8_16);

   assign take_x   = (ctrl_cur.digit_count == 2'd1) && is_x && !ctrl_cur.base_fixed &&
                     ((ctrl_cur.current_base == atis_pkg::BASE_AUTO) ||
                      (ctrl_cur.current_base == atis_pkg::BASE_16)) && lz_now;
   assign take_oct = (ctrl_cur.digit_count == 2'd1) && is_oct && !ctrl_cur.base_fixed &&
                     ((ctrl_cur.current_base == atis_pkg::BASE_AUTO) ||
                      (ctrl_cur.current_base == atis_pkg::BASE_8)) && lz_now;
   assign take_dec = (ctrl_cur.digit_count == 2'd0) && is_dec && !ctrl_cur.base_fixed &&
                     ((ctrl_cur.current_base == atis_pkg::BASE_AUTO) ||
                      (ctrl_cur.current_base == atis_pkg::BASE_10)) && !lz_now;

   assign base_now = take_oct ? atis_pkg::BASE_8 :
                     take_dec ? atis_pkg::BASE_10 : ctrl_cur.current_base;

   // '0' is a digit in every base, auto included
   assign raw_dv = atis_pkg::raw_digit(character);
   assign dv_ok  = is_zero ||
                   (!end_of_input && (raw_dv < atis_pkg::base_radix(base_now)));

   assign rec_inc = (rec_cur < REC_BITS'(UNDO_DEPTH)) ? rec_cur + 1'b1 : rec_cur;

   // constant-base shift-add
   always_comb begin
      unique case (base_now)
         atis_pkg::BASE_8:  scaled = acc_cur << 3;
         atis_pkg::BASE_10: scaled = (acc_cur << 3) + (acc_cur << 1);
         atis_pkg::BASE_16: scaled = acc_cur << 4;
         default:           scaled = '0;
      endcase
   end

   assign signed_acc = ctrl_cur.negative_seen ? ('0 - acc_cur) : acc_cur;
   assign wide_acc   = 64'(signed_acc);

   always_comb begin
      unique case (result_size)
         atis_pkg::SIZE_8:  size_mask = 64'h0000_0000_0000_00ff;
         atis_pkg::SIZE_16: size_mask = 64'h0000_0000_0000_ffff;
         atis_pkg::SIZE_32: size_mask = 64'h0000_0000_ffff_ffff;
         default:           size_mask = '1;
      endcase
   end

   always_comb begin
      ctrl_next  = ctrl_cur;
      acc_next   = acc_cur;
      rec_next   = rec_cur;
      has_result = 1'b0;
      result     = '0;
      value      = '0;
      if (!((rec_cur == '0) && !end_of_input && is_space)) begin
         rec_next = rec_inc;
         if (take_minus) begin
            ctrl_next.negative_seen = 1'b1;
         end else begin
            ctrl_next.leading_zero_seen = lz_now;
            if (take_x) begin
               ctrl_next.current_base      = atis_pkg::BASE_16;
               ctrl_next.leading_zero_seen = 1'b0;
               ctrl_next.base_fixed        = 1'b1;
               ctrl_next.digit_count       = 2'd0;
            end else begin
               if (take_oct) begin
                  ctrl_next.current_base      = atis_pkg::BASE_8;
                  ctrl_next.base_fixed        = 1'b1;
                  ctrl_next.leading_zero_seen = 1'b0;
               end else if (take_dec) begin
                  ctrl_next.current_base = atis_pkg::BASE_10;
                  ctrl_next.base_fixed   = 1'b1;
               end
               if (!dv_ok) begin
                  // terminator: form the result and start a new run
                  has_result = 1'b1;
                  if (ctrl_cur.digit_count == 2'd0) begin
                     result.status         = atis_pkg::STATUS_NO_DIGIT;
                     result.pushback_count = rec_inc[2:0];
                  end else begin
                     result.status         = atis_pkg::STATUS_OK;
                     result.pushback_count = 3'd1;
                     value                 = wide_acc & size_mask;
                  end
                  ctrl_next = atis_pkg::fresh_ctrl(conversion);
                  acc_next  = '0;
                  rec_next  = '0;
               end else begin
                  acc_next = scaled + VALUE_BITS'(raw_dv[3:0] & {4{!is_zero}});
                  if (ctrl_cur.digit_count < atis_pkg::DIGIT_SAT) begin
                     ctrl_next.digit_count = ctrl_cur.digit_count + 2'd1;
                  end
               end
            end
         end
      end
   end

endmodule

// ===== sv/ascii_integer_token_scanner_core.sv =====
// ascii integer token scanner: an accepted word sits in the input register while the scan
// step runs, and the result register loads when the step fires; a held result stalls the step.
// throughput is one word per cycle while no held result stalls the step; the only loop is
// the shift-add state update.
// synchronous active-high reset clears both registers' valid flags and the scan state,
// sets conversion to signed decimal and result size to 32 bits; no clearing pass.
// depends on atis_pkg and atis_step
module ascii_integer_token_scanner_core #(
   parameter int UNDO_DEPTH = 4,
   parameter int VALUE_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_character,
   input  logic        req_end_of_input,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_value,
   output logic        rsp_status,
   output logic [2:0]  rsp_pushback_count,
   // configuration writes
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [2:0]  csr_write_data
);

   localparam int REC_BITS = $clog2(UNDO_DEPTH + 1);

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_char_ff, in_char_in;
   logic                  in_eoi_ff, in_eoi_in;

   // configuration
   logic [2:0]            conversion_ff, conversion_in;
   logic [1:0]            result_size_ff, result_size_in;

   // scan state
   atis_pkg::ctrl_type    ctrl_ff, ctrl_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [REC_BITS-1:0]   rec_ff, rec_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic [63:0]           out_value_ff, out_value_in;
   atis_pkg::result_type  out_res_ff, out_res_in;

   // step outputs
   atis_pkg::ctrl_type    step_ctrl;
   logic [VALUE_BITS-1:0] step_acc;
   logic [REC_BITS-1:0]   step_rec;
   logic                  step_has_result;
   atis_pkg::result_type  step_res;
   logic [63:0]           step_value;

   logic                  req_take;
   logic                  out_free;
   logic                  step_fire;

   // the step may run unless a finished result is still held by the consumer
   assign out_free  = !(out_valid_ff && rsp_stall);
   assign step_fire = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   atis_step #(
      .UNDO_DEPTH (UNDO_DEPTH),
      .VALUE_BITS (VALUE_BITS),
      .REC_BITS   (REC_BITS)
   ) u_step (
      .character    (in_char_ff),
      .end_of_input (in_eoi_ff),
      .conversion   (conversion_ff),
      .result_size  (result_size_ff),
      .ctrl_cur     (ctrl_ff),
      .acc_cur      (acc_ff),
      .rec_cur      (rec_ff),
      .ctrl_next    (step_ctrl),
      .acc_next     (step_acc),
      .rec_next     (step_rec),
      .has_result   (step_has_result),
      .result       (step_res),
      .value        (step_value)
   );

   // input register: refills in the same cycle it drains
   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_eoi_in   = in_eoi_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_char_in  = req_character;
         in_eoi_in   = req_end_of_input;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end
   end

   // configuration and scan state
   always_comb begin
      conversion_in  = conversion_ff;
      result_size_in = result_size_ff;
      ctrl_in        = ctrl_ff;
      acc_in         = acc_ff;
      rec_in         = rec_ff;
      if (csr_write_enable && (csr_index == atis_pkg::CSR_CONVERSION)) begin
         // a new conversion abandons the run in progress
         conversion_in = csr_write_data;
         ctrl_in       = atis_pkg::fresh_ctrl(csr_write_data);
         acc_in        = '0;
         rec_in        = '0;
      end else if (step_fire) begin
         ctrl_in = step_ctrl;
         acc_in  = step_acc;
         rec_in  = step_rec;
      end
      if (csr_write_enable && (csr_index == atis_pkg::CSR_RESULT_SIZE)) begin
         result_size_in = csr_write_data[1:0];
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_res_in   = out_res_ff;
      if (step_fire && step_has_result) begin
         out_valid_in = 1'b1;
         out_value_in = step_value;
         out_res_in   = step_res;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         conversion_ff  <= atis_pkg::CONV_SIGNED_DEC;
         result_size_ff <= atis_pkg::SIZE_RESET;
         ctrl_ff        <= atis_pkg::fresh_ctrl(atis_pkg::CONV_SIGNED_DEC);
         acc_ff         <= '0;
         rec_ff         <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         conversion_ff  <= conversion_in;
         result_size_ff <= result_size_in;
         ctrl_ff        <= ctrl_in;
         acc_ff         <= acc_in;
         rec_ff         <= rec_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_char_ff   <= in_char_in;
      in_eoi_ff    <= in_eoi_in;
      out_value_ff <= out_value_in;
      out_res_ff   <= out_res_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_value          = out_value_ff;
   assign rsp_status         = out_res_ff.status;
   assign rsp_pushback_count = out_res_ff.pushback_count;

   // a no-number result carries a zero value and pushes back at least the terminator
   a_no_digit_shape: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_res_ff.status == atis_pkg::STATUS_NO_DIGIT) |->
         (out_value_ff == 64'd0) && (out_res_ff.pushback_count != 3'd0))
      else $error("no-number result with nonzero value or empty pushback");

   // a parsed number pushes back only its terminator
   a_ok_pushback: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_res_ff.status == atis_pkg::STATUS_OK) |->
         (out_res_ff.pushback_count == 3'd1))
      else $error("parsed number with pushback other than one");

   // a new result only ever follows a step that ran
   a_result_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(step_fire && step_has_result))
      else $error("result appeared without a terminating step");

   // a fixed base is never auto
   a_fixed_base: assert property (@(posedge clock) disable iff (reset)
      ctrl_ff.base_fixed |-> (ctrl_ff.current_base != atis_pkg::BASE_AUTO))
      else $error("base marked fixed while still auto");

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for ascii_integer_token_scanner_core, one character word per item
// keeps its own scan state to predict every token result; depends on atis_pkg and the core
module tb_top;

   // the package has no name for this code; 5..7 fall back to it as well
   localparam logic [2:0] CONV_UNSIGNED_DEC = 3'd3;
   localparam int         UNDO_LIMIT        = 4;
   // cycles for the two-stage pipe to empty, with margin
   localparam int         SETTLE_CYCLES     = 6;

   typedef struct {
      logic [63:0] value;
      logic        status;
      logic [2:0]  pushback;
   } token_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_character = 8'h00;
   logic        req_end_of_input = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_value;
   logic        rsp_status;
   logic [2:0]  rsp_pushback_count;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = atis_pkg::CSR_CONVERSION;
   logic [2:0]  csr_write_data = 3'd0;

   // expected token results, oldest first
   token_result_type token_results_due[$];
   token_result_type due;
   int error_count = 0;
   int scanned_words = 0;

   // idling controls, set by the tests and read by the sender and the receiver process
   bit send_idling = 1'b1;
   bit recv_idling = 1'b1;
   int hold_cycles = 0;

   // scan state mirror
   logic [63:0]        acc;
   logic [1:0]         ndigits;
   logic               neg_seen;
   logic               lead_zero;
   logic               base_locked;
   atis_pkg::base_type radix_sel;
   logic [2:0]         recorded;
   logic [2:0]         cfg_conv = atis_pkg::CONV_SIGNED_DEC;
   logic [1:0]         cfg_size = atis_pkg::SIZE_32;
   bit                 word_ignored;

   ascii_integer_token_scanner_core DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_character      (req_character),
      .req_end_of_input   (req_end_of_input),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_value          (rsp_value),
      .rsp_status         (rsp_status),
      .rsp_pushback_count (rsp_pushback_count),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // scan predictor
   // ---------------------------------------------------------------

   function automatic int radix_of(input atis_pkg::base_type b);
      case (b)
         atis_pkg::BASE_8:  return 8;
         atis_pkg::BASE_10: return 10;
         atis_pkg::BASE_16: return 16;
         default: return 0;   // auto: only '0' counts as a digit
      endcase
   endfunction

   // digit value in the given radix, -1 when the character is none
   function automatic int digit_of(input logic [7:0] ch, input int radix);
      int v;
      v = -1;
      if (ch == atis_pkg::CH_ZERO) return 0;
      if (ch >= atis_pkg::CH_ZERO && ch <= atis_pkg::CH_NINE)
         v = int'(ch - atis_pkg::CH_ZERO);
      else if (ch >= atis_pkg::CH_LO_A && ch <= atis_pkg::CH_LO_F)
         v = int'(ch - atis_pkg::CH_LO_A) + 10;
      else if (ch >= atis_pkg::CH_UP_A && ch <= atis_pkg::CH_UP_F)
         v = int'(ch - atis_pkg::CH_UP_A) + 10;
      if (v < 0 || v >= radix) return -1;
      return v;
   endfunction

   function automatic void new_token();
      acc         = '0;
      ndigits     = '0;
      neg_seen    = 1'b0;
      lead_zero   = 1'b0;
      base_locked = 1'b0;
      recorded    = '0;
      case (cfg_conv)
         atis_pkg::CONV_SIGNED_AUTO:  radix_sel = atis_pkg::BASE_AUTO;
         atis_pkg::CONV_UNSIGNED_OCT: radix_sel = atis_pkg::BASE_8;
         atis_pkg::CONV_UNSIGNED_HEX: radix_sel = atis_pkg::BASE_16;
         default:                     radix_sel = atis_pkg::BASE_10;
      endcase
   endfunction

   // advance the mirror by one accepted word, queue a result when a token ends
   function automatic void scan_word(input logic [7:0] ch, input logic eoi);
      int r;
      int dv;
      logic is_chr;
      logic [63:0] v;
      token_result_type res;
      is_chr = !eoi;
      word_ignored = 1'b0;
      // leading blanks never start a token
      if (recorded == 0 && is_chr && (ch == atis_pkg::CH_SPACE ||
          (ch >= atis_pkg::CH_TAB && ch <= atis_pkg::CH_CR))) begin
         word_ignored = 1'b1;
         return;
      end
      if (recorded < UNDO_LIMIT) recorded++;
      // sign only for signed conversions, before any digit or prefix
      if (is_chr && ch == atis_pkg::CH_MINUS && !neg_seen && ndigits == 0 && !base_locked &&
          (cfg_conv == atis_pkg::CONV_SIGNED_DEC ||
           cfg_conv == atis_pkg::CONV_SIGNED_AUTO)) begin
         neg_seen = 1'b1;
         return;
      end
      r = radix_of(radix_sel);
      if (is_chr && ndigits == 0 && ch == atis_pkg::CH_ZERO && !base_locked && r != 10 &&
          !lead_zero)
         lead_zero = 1'b1;
      if (is_chr && ndigits == 1 && (ch == atis_pkg::CH_LO_X || ch == atis_pkg::CH_UP_X) &&
          !base_locked && (r == 0 || r == 16) && lead_zero) begin
         // hex prefix: the zero before it does not count as a digit
         radix_sel   = atis_pkg::BASE_16;
         lead_zero   = 1'b0;
         base_locked = 1'b1;
         ndigits     = '0;
         return;
      end else if (is_chr && ndigits == 1 && ch >= atis_pkg::CH_ZERO &&
                   ch <= atis_pkg::CH_SEVEN && !base_locked && (r == 0 || r == 8) &&
                   lead_zero) begin
         radix_sel   = atis_pkg::BASE_8;
         base_locked = 1'b1;
         lead_zero   = 1'b0;
      end else if (is_chr && ndigits == 0 && ch >= atis_pkg::CH_ZERO &&
                   ch <= atis_pkg::CH_NINE && !base_locked && (r == 0 || r == 10) &&
                   !lead_zero) begin
         radix_sel   = atis_pkg::BASE_10;
         base_locked = 1'b1;
      end
      r  = radix_of(radix_sel);
      dv = is_chr ? digit_of(ch, r) : -1;
      if (dv < 0) begin
         if (ndigits == 0) begin
            res.value    = '0;
            res.status   = atis_pkg::STATUS_NO_DIGIT;
            res.pushback = recorded;
         end else begin
            v = neg_seen ? (64'd0 - acc) : acc;
            case (cfg_size)
               atis_pkg::SIZE_8:  v = v & 64'h0000_0000_0000_00ff;
               atis_pkg::SIZE_16: v = v & 64'h0000_0000_0000_ffff;
               atis_pkg::SIZE_32: v = v & 64'h0000_0000_ffff_ffff;
               default: ;
            endcase
            res.value    = v;
            res.status   = atis_pkg::STATUS_OK;
            res.pushback = 3'd1;
         end
         token_results_due.push_back(res);
         new_token();
         return;
      end
      acc = acc * 64'(r) + 64'(dv);
      if (ndigits < atis_pkg::DIGIT_SAT) ndigits++;
   endfunction

   // ---------------------------------------------------------------
   // receiver: random stall bursts, plus a long hold when asked for
   // ---------------------------------------------------------------
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            stall_left  = hold_cycles;
            hold_cycles = 0;
         end else if (stall_left == 0 && recv_idling && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 6);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // result checker, compares against the oldest pending token
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (token_results_due.size() == 0) begin
            $error("unexpected result: value %h status %0d pushback_count %0d",
                   rsp_value, rsp_status, rsp_pushback_count);
            error_count++;
         end else begin
            due = token_results_due.pop_front();
            if (rsp_value !== due.value) begin
               $error("value: expected %h, got %h", due.value, rsp_value);
               error_count++;
            end
            if (rsp_status !== due.status) begin
               $error("status: expected %0d, got %0d", due.status, rsp_status);
               error_count++;
            end
            if (rsp_pushback_count !== due.pushback) begin
               $error("pushback_count: expected %0d, got %0d", due.pushback,
                      rsp_pushback_count);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------

   // offer one word, hold it until accepted, then update the mirror
   task automatic send_word(input logic [7:0] ch, input logic eoi);
      int gap;
      @(negedge clock);
      if (send_idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_character    <= ch;
      req_end_of_input <= eoi;
      do @(posedge clock); while (!(req_valid && !req_stall));
      scan_word(ch, eoi);
      if (!word_ignored) scanned_words++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
   endtask

   // stop offering and wait for every pending token result, then let the pipe empty
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (token_results_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // register write; only called with the block idle
   task automatic write_reg(input logic idx, input logic [2:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == atis_pkg::CSR_CONVERSION) begin
         cfg_conv = data;
         new_token();   // a conversion write drops the token in progress
      end else begin
         cfg_size = data[1:0];
      end
   endtask

   function automatic logic [7:0] pick_digit(input atis_pkg::base_type kind);
      logic [7:0] v;
      v = 8'($urandom_range(0, kind == atis_pkg::BASE_8 ? 7 :
                               (kind == atis_pkg::BASE_10 ? 9 : 15)));
      if (v < 8'd10) return atis_pkg::CH_ZERO + v;
      return ($urandom_range(0, 1) ? atis_pkg::CH_LO_A : atis_pkg::CH_UP_A) + v - 8'd10;
   endfunction

   // one well-formed token for the current conversion, random content and terminator
   task automatic send_token();
      atis_pkg::base_type kind;
      int n;
      int i;
      logic auto_mode;
      auto_mode = (cfg_conv == atis_pkg::CONV_SIGNED_AUTO);
      case (cfg_conv)
         atis_pkg::CONV_SIGNED_AUTO: begin
            case ($urandom_range(0, 2))
               0:       kind = atis_pkg::BASE_8;
               1:       kind = atis_pkg::BASE_10;
               default: kind = atis_pkg::BASE_16;
            endcase
         end
         atis_pkg::CONV_UNSIGNED_OCT: kind = atis_pkg::BASE_8;
         atis_pkg::CONV_UNSIGNED_HEX: kind = atis_pkg::BASE_16;
         default:                     kind = atis_pkg::BASE_10;
      endcase
      if ($urandom_range(0, 4) == 0)
         send_word($urandom_range(0, 5) == 0 ? atis_pkg::CH_SPACE :
                   8'($urandom_range(atis_pkg::CH_TAB, atis_pkg::CH_CR)), 1'b0);
      // sign also goes to unsigned conversions, where it ends the token
      if ($urandom_range(0, 3) == 0) send_word(atis_pkg::CH_MINUS, 1'b0);
      if (kind == atis_pkg::BASE_16 && (auto_mode || $urandom_range(0, 1))) begin
         send_word(atis_pkg::CH_ZERO, 1'b0);
         send_word($urandom_range(0, 1) ? atis_pkg::CH_LO_X : atis_pkg::CH_UP_X, 1'b0);
      end else if (kind == atis_pkg::BASE_8 && (auto_mode || $urandom_range(0, 1))) begin
         send_word(atis_pkg::CH_ZERO, 1'b0);
      end else if (kind == atis_pkg::BASE_10 && auto_mode) begin
         // nonzero lead so auto mode settles on decimal
         send_word(atis_pkg::CH_ZERO + 8'($urandom_range(1, 9)), 1'b0);
      end
      // mostly short; sometimes long enough to wrap 64 bits
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 6);
      for (i = 0; i < n; i++) send_word(pick_digit(kind), 1'b0);
      case ($urandom_range(0, 3))
         0:       send_word(8'($urandom), 1'b1);
         1:       send_word(atis_pkg::CH_SPACE, 1'b0);
         2:       send_word(",", 1'b0);
         default: send_word(8'($urandom), 1'b0);
      endcase
   endtask

   // random bytes, some end marks among them
   task automatic send_noise();
      int n;
      int i;
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) send_word(8'($urandom), $urandom_range(0, 7) == 0);
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   task automatic test_directed();
      // signed decimal, 32 bits out of reset: blanks skipped, sign, end mark ends it
      send_text(" -7");
      send_word(8'hff, 1'b1);
      drain_results();
      write_reg(atis_pkg::CSR_CONVERSION, atis_pkg::CONV_SIGNED_AUTO);
      write_reg(atis_pkg::CSR_RESULT_SIZE, {1'b0, atis_pkg::SIZE_64});
      send_text("0xF;");   // hex prefix
      send_text("07,");    // octal from a leading zero
      send_text("09");     // lone zero, value 0 at the next byte
      send_text("-0xg");   // prefix without digits, four bytes pushed back
      drain_results();
      // unused conversion code behaves as unsigned decimal; 8-bit truncation
      write_reg(atis_pkg::CSR_CONVERSION, 3'd7);
      write_reg(atis_pkg::CSR_RESULT_SIZE, {1'b0, atis_pkg::SIZE_8});
      send_text("300");
      send_word(8'h00, 1'b0);
      // token in progress is dropped by a conversion write
      send_text("12");
      drain_results();
      write_reg(atis_pkg::CSR_CONVERSION, atis_pkg::CONV_UNSIGNED_HEX);
      write_reg(atis_pkg::CSR_RESULT_SIZE, {1'b0, atis_pkg::SIZE_16});
      send_text("fF");
      send_word(8'hff, 1'b0);
      drain_results();
   endtask

   task automatic test_random_tokens(input int word_goal, input bit with_idling);
      int first;
      first = scanned_words;
      while (scanned_words - first < word_goal) begin
         if ($urandom_range(0, 5) == 0) begin
            drain_results();
            if ($urandom_range(0, 3) != 0)
               write_reg(atis_pkg::CSR_CONVERSION, 3'($urandom_range(0, 7)));
            // bit 2 of the data is ignored for the size register
            if ($urandom_range(0, 3) != 0)
               write_reg(atis_pkg::CSR_RESULT_SIZE, 3'($urandom_range(0, 7)));
            send_idling = with_idling && ($urandom_range(0, 3) != 0);
            recv_idling = with_idling && ($urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 7) == 0) send_noise();
         else send_token();
      end
   endtask

   // receiver holds off while words keep coming, then sender waits for all results
   task automatic test_backpressure();
      int i;
      drain_results();
      write_reg(atis_pkg::CSR_CONVERSION, CONV_UNSIGNED_DEC);
      hold_cycles = 200;
      for (i = 0; i < 20; i++) send_token();
      drain_results();
   endtask

   task automatic test_full_rate();
      send_idling = 1'b0;
      recv_idling = 1'b0;
      test_random_tokens(400, 1'b0);
   endtask

   initial begin
      int wait_count;
      new_token();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_tokens(1000, 1'b1);
      test_backpressure();
      test_full_rate();

      // wait for outstanding results with a bound, then let the pipe settle
      @(negedge clock);
      req_valid <= 1'b0;
      wait_count = 0;
      while (token_results_due.size() != 0 && wait_count < 5000) begin
         @(negedge clock);
         wait_count++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (token_results_due.size() != 0) begin
         $error("%0d token results never arrived", token_results_due.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/atis_pkg.sv
sv/atis_step.sv
sv/ascii_integer_token_scanner_core.sv
tb/tb_top.sv
